### sv/nps_pkg.sv
// Shared constants and types for the nearest position search block.
`timescale 1ns / 1ps

package nps_pkg;

    // Default geometry of the position table.
    localparam int DEF_MAX_POSITIONS = 1024;
    localparam int DEF_COORD_BITS    = 16;

    // Fixed port widths.
    localparam int OP_W    = 2;
    localparam int FIELD_W = 16;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    // Squared distances saturate at this width.
    localparam int DIST_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

endpackage

### sv/nearest_position_search_3d_top.sv
// Top level of the 3-D nearest position search: table control, scan pipeline, result port.
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low. Clear, append and the
// unused op code strobe o_valid in the next cycle and keep busy low,
// so such requests may follow one per cycle. A query on an empty table also answers in the
// next cycle. A query on a table of N entries raises busy and strobes its result once the
// last entry has passed the distance pipe: the position RAM gives one entry per
// cycle on its single read port, and each entry then runs through a four-stage distance pipe
// (difference, square, sum, compare). busy falls in the same cycle as the strobe. The
// receiver cannot hold results off: each result is on the o_ ports for exactly one cycle
// with o_valid and must be captured then. Entry count and bounding box outputs always show
// the current table state. Coordinates are Q8.8; the low COORD_BITS bits of each input are
// taken as a signed value, and box outputs are the low 16 bits of the sign-extended corner.
module nearest_position_search_3d_top
    import nps_pkg::*;
#(
    parameter int MAX_POSITIONS = DEF_MAX_POSITIONS,
    parameter int COORD_BITS    = DEF_COORD_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    i_op,
    input  logic [FIELD_W-1:0] i_coord_x,
    input  logic [FIELD_W-1:0] i_coord_y,
    input  logic [FIELD_W-1:0] i_coord_z,
    output logic               o_valid,
    output logic [INDEX_W-1:0] o_nearest_index,
    output logic [COUNT_W-1:0] o_entry_count,
    output logic               o_dropped,
    output logic [FIELD_W-1:0] o_box_min_x,
    output logic [FIELD_W-1:0] o_box_min_y,
    output logic [FIELD_W-1:0] o_box_min_z,
    output logic [FIELD_W-1:0] o_box_max_x,
    output logic [FIELD_W-1:0] o_box_max_y,
    output logic [FIELD_W-1:0] o_box_max_z
);

    localparam int IDX_W = $clog2(MAX_POSITIONS);
    localparam int CNT_W = $clog2(MAX_POSITIONS + 1);
    localparam int MAG_W = COORD_BITS + 1;
    localparam int ENT_W = 3 * COORD_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    // Low COORD_BITS bits of a port field, read as signed.
    function automatic t_coord f_coord(input logic [FIELD_W-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        return ext[COORD_BITS-1:0];
    endfunction

    // Low 16 bits of the sign-extended coordinate.
    function automatic logic [FIELD_W-1:0] f_field(input t_coord v);
        logic signed [31:0] ext;
        ext = 32'(v);
        return ext[FIELD_W-1:0];
    endfunction

    // Control state
    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    t_coord               r_box_min [3];
    t_coord               r_box_max [3];
    t_coord               r_tgt [3];
    logic [IDX_W-1:0]     r_scan_addr;
    logic [IDX_W-1:0]     r_last_addr;
    logic                 r_valid;
    logic [INDEX_W-1:0]   r_index_out;
    logic                 r_dropped;

    // Scan pipeline
    logic                 r_p0_vld, r_p1_vld, r_p2_vld, r_p3_vld;
    logic                 r_p0_last, r_p1_last, r_p2_last, r_p3_last;
    logic [IDX_W-1:0]     r_p0_idx, r_p1_idx, r_p2_idx, r_p3_idx;
    logic [MAG_W-1:0]     r_mag [3];
    logic [DIST_W-1:0]    r_sq [3];
    logic [DIST_W-1:0]    r_dist;
    logic [DIST_W-1:0]    r_best_dist;
    logic [IDX_W-1:0]     r_best_idx;

    // Combinational
    t_op                  w_op;
    logic                 w_accept;
    logic                 w_full;
    t_coord               w_p [3];
    logic                 w_wr_en;
    logic                 w_rd_en;
    logic [ENT_W-1:0]     w_wr_data;
    logic [ENT_W-1:0]     w_rd_data;
    t_coord               w_q [3];
    logic signed [MAG_W-1:0] w_diff [3];
    logic [MAG_W-1:0]     w_mag [3];
    logic [DIST_W-1:0]    w_mag64 [3];
    logic [31:0]          w_m32 [3];
    logic [DIST_W-1:0]    w_sq [3];
    logic [DIST_W+1:0]    w_sum;
    logic [DIST_W-1:0]    w_dist;
    logic                 w_take;
    logic [IDX_W-1:0]     n_best_idx;

    assign w_op     = t_op'(i_op);
    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_full   = (r_count >= CNT_W'(MAX_POSITIONS));

    assign w_p[0] = f_coord(i_coord_x);
    assign w_p[1] = f_coord(i_coord_y);
    assign w_p[2] = f_coord(i_coord_z);

    // Entry layout in RAM: {z, y, x}
    assign w_wr_data = {w_p[2], w_p[1], w_p[0]};
    assign w_wr_en   = w_accept && (w_op == OP_APPEND) && !w_full;
    assign w_rd_en   = (r_state == ST_SCAN);

    nps_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_POSITIONS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_scan_addr),
        .o_rd_data (w_rd_data)
    );

    // Distance datapath: |t - q| per axis, then 32x32 square, saturated sum
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            w_q[d]     = w_rd_data[d*COORD_BITS +: COORD_BITS];
            w_diff[d]  = MAG_W'(r_tgt[d]) - MAG_W'(w_q[d]);
            w_mag[d]   = w_diff[d][MAG_W-1] ? MAG_W'(-w_diff[d]) : w_diff[d];
            w_mag64[d] = DIST_W'(r_mag[d]);
            w_m32[d]   = w_mag64[d][31:0];
            // magnitude above 32 bits saturates the square
            w_sq[d]    = (|w_mag64[d][DIST_W-1:32]) ? '1
                                                   : (DIST_W'(w_m32[d]) * DIST_W'(w_m32[d]));
        end
        w_sum  = (DIST_W+2)'(r_sq[0]) + (DIST_W+2)'(r_sq[1]) + (DIST_W+2)'(r_sq[2]);
        w_dist = (|w_sum[DIST_W+1:DIST_W]) ? '1 : w_sum[DIST_W-1:0];
        // strict less-than keeps ties at the lowest index
        w_take     = r_p3_vld && ((r_p3_idx == '0) || (r_dist < r_best_dist));
        n_best_idx = w_take ? r_p3_idx : r_best_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else begin
            r_p0_vld <= w_rd_en;
            r_p1_vld <= r_p0_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
        r_p0_idx  <= r_scan_addr;
        r_p0_last <= (r_scan_addr == r_last_addr);
        r_p1_idx  <= r_p0_idx;
        r_p1_last <= r_p0_last;
        r_p2_idx  <= r_p1_idx;
        r_p2_last <= r_p1_last;
        r_p3_idx  <= r_p2_idx;
        r_p3_last <= r_p2_last;
        for (int d = 0; d < 3; d++) begin
            r_mag[d] <= w_mag[d];
            r_sq[d]  <= w_sq[d];
        end
        r_dist <= w_dist;
        if (w_take) begin
            r_best_dist <= r_dist;
            r_best_idx  <= r_p3_idx;
        end
    end

    // Request control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            for (int d = 0; d < 3; d++) begin
                r_box_min[d] <= '0;
                r_box_max[d] <= '0;
            end
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_index_out <= '0;
                        r_dropped   <= 1'b0;
                        unique case (w_op)
                            OP_CLEAR: begin
                                r_valid <= 1'b1;
                                r_count <= '0;
                                for (int d = 0; d < 3; d++) begin
                                    r_box_min[d] <= '0;
                                    r_box_max[d] <= '0;
                                end
                            end
                            OP_APPEND: begin
                                r_valid <= 1'b1;
                                if (w_full) begin
                                    r_dropped <= 1'b1;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                    // first entry sets both corners
                                    for (int d = 0; d < 3; d++) begin
                                        if ((r_count == '0) || (w_p[d] < r_box_min[d])) begin
                                            r_box_min[d] <= w_p[d];
                                        end
                                        if ((r_count == '0) || (w_p[d] > r_box_max[d])) begin
                                            r_box_max[d] <= w_p[d];
                                        end
                                    end
                                end
                            end
                            OP_QUERY: begin
                                if (r_count == '0) begin
                                    r_valid <= 1'b1;
                                end else begin
                                    r_tgt       <= w_p;
                                    r_scan_addr <= '0;
                                    r_last_addr <= IDX_W'(r_count - 1'b1);
                                    r_state     <= ST_SCAN;
                                end
                            end
                            OP_NONE: begin
                                r_valid <= 1'b1;
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_scan_addr <= r_scan_addr + 1'b1;
                    if (r_scan_addr == r_last_addr) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_p3_vld && r_p3_last) begin
                        r_valid     <= 1'b1;
                        r_index_out <= INDEX_W'(n_best_idx);
                        r_dropped   <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_nearest_index = r_index_out;
    assign o_dropped       = r_dropped;
    assign o_entry_count   = COUNT_W'(r_count);
    assign o_box_min_x     = f_field(r_box_min[0]);
    assign o_box_min_y     = f_field(r_box_min[1]);
    assign o_box_min_z     = f_field(r_box_min[2]);
    assign o_box_max_x     = f_field(r_box_max[0]);
    assign o_box_max_y     = f_field(r_box_max[1]);
    assign o_box_max_z     = f_field(r_box_max[2]);

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POSITIONS))
        else $error("entry count beyond table size");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobed while busy");

    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(r_p0_vld || r_p1_vld || r_p2_vld || r_p3_vld))
        else $error("scan pipe active while idle");

    a_short_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op != OP_QUERY)) |=> o_valid)
        else $error("short request gave no result");

    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> ((r_box_min[0] <= r_box_max[0]) &&
                             (r_box_min[1] <= r_box_max[1]) &&
                             (r_box_min[2] <= r_box_max[2])))
        else $error("bounding box corners out of order");

endmodule

### sv/nps_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module nps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
